// File: hw/rtl/tsis_pkg.sv
// ----------------------------------------------------------------------------
// tsis_pkg: shared types, constants and functions
// Seed table builder, double-precision classification helpers and the
// sideband word that rides along the refinement pipeline.
// ----------------------------------------------------------------------------
package tsis_pkg;

  localparam int SEED_ENTRIES = 512;
  localparam int NEWTON_MAX   = 3;
  localparam int CFG_ADDR_W   = 3;

  // register index (paddr bit 2)
  localparam logic REG_NEWTON_STEPS = 1'b0;
  localparam logic [1:0] NEWTON_STEPS_RST = 2'd2;

  localparam logic [63:0] DBL_ONE_AND_HALF = 64'h3FF8_0000_0000_0000;
  localparam logic [63:0] DBL_DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DBL_QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [52:0] ONE_AND_HALF_MANT = 53'h18_0000_0000_0000;
  localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
  localparam logic [10:0] DBL_BIAS    = 11'd1023;

  typedef logic [7:0] seed_rom_t [SEED_ENTRIES];

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] y;
  } tag_t;

  function automatic logic dbl_is_nan(input logic [63:0] d);
    return (d[62:52] == DBL_EXP_MAX) && (d[51:0] != '0);
  endfunction

  function automatic logic dbl_is_inf(input logic [63:0] d);
    return (d[62:52] == DBL_EXP_MAX) && (d[51:0] == '0);
  endfunction

  function automatic logic dbl_is_zero(input logic [63:0] d);
    return d[62:52] == '0;
  endfunction

  // Seed mantissas: rounded 1/sqrt over [0.5,2), built at elaboration with
  // exact integer sqrt, long division and three round-to-nearest-even steps.
  function automatic seed_rom_t seed_rom_build();
    seed_rom_t    rom;
    logic [127:0] n;
    logic [127:0] rm;
    logic [127:0] rt;
    logic [127:0] tr;
    logic [127:0] q;
    logic [53:0]  mant;
    logic [53:0]  dm;
    logic [24:0]  f24;
    logic [22:0]  frac;
    logic [23:0]  sum;
    logic [25:0]  k;
    logic         g;
    logic         st;
    for (int i = 0; i < SEED_ENTRIES; i++) begin
      k = 26'h80_0000 | 26'((i & 255) << 15);
      if (i >= 256) k = k << 1;
      n  = {102'b0, k} << 84;
      rm = '0;
      rt = '0;
      for (int p = 55; p >= 0; p--) begin
        rm = (rm << 2) | ((n >> (2 * p)) & 128'd3);
        tr = (rt << 2) | 128'd1;
        if (rm >= tr) begin
          rm = rm - tr;
          rt = (rt << 1) | 128'd1;
        end else begin
          rt = rt << 1;
        end
      end
      if (rt[54]) begin
        mant = 54'(rt >> 2);
        g    = rt[1];
        st   = rt[0] | (rm != '0);
      end else begin
        mant = 54'(rt >> 1);
        g    = rt[0];
        st   = (rm != '0);
      end
      if (g && (st || mant[0])) mant = mant + 54'd1;
      // 2^107 / mant
      rm = '0;
      q  = '0;
      for (int b = 107; b >= 0; b--) begin
        rm = (rm << 1) | ((b == 107) ? 128'd1 : 128'd0);
        if (rm >= {74'b0, mant}) begin
          rm   = rm - {74'b0, mant};
          q[b] = 1'b1;
        end
      end
      if (q[55]) begin
        dm = 54'd1 << 52;
      end else begin
        dm = 54'(q >> 2);
        g  = q[1];
        st = q[0] | (rm != '0);
        if (g && (st || dm[0])) dm = dm + 54'd1;
      end
      if (dm[53]) begin
        frac = '0;
      end else begin
        f24 = 25'(dm >> 29);
        g   = dm[28];
        st  = |dm[27:0];
        if (g && (st || f24[0])) f24 = f24 + 25'd1;
        frac = f24[22:0];
      end
      sum    = {1'b0, frac} + 24'h2000;
      rom[i] = sum[22:15];
    end
    rom[SEED_ENTRIES / 2] = 8'hFF;
    return rom;
  endfunction

endpackage

// File: hw/rtl/tsis_dmul.sv
// ----------------------------------------------------------------------------
// tsis_dmul: three-stage double-precision multiplier
// Stage 1 forms four partial products, stage 2 sums them, stage 3
// normalizes and rounds to nearest-even. Sideband word follows the data.
// ----------------------------------------------------------------------------
module tsis_dmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [63:0]    in_a,
  input  logic [63:0]    in_b,
  input  tsis_pkg::tag_t in_tag,
  output logic           out_vld,
  output logic [63:0]    out_res,
  output tsis_pkg::tag_t out_tag
);
  import tsis_pkg::*;

  // stage 1
  logic        vld1_r;
  tag_t        tag1_r;
  logic        spec1_r, spec1_nxt;
  logic [63:0] specv1_r, specv1_nxt;
  logic        sign1_r;
  logic [12:0] exp1_r;
  logic [53:0] hh1_r;
  logic [52:0] hl1_r, lh1_r;
  logic [51:0] ll1_r;
  logic [52:0] ma, mb;

  assign ma = {1'b1, in_a[51:0]};
  assign mb = {1'b1, in_b[51:0]};

  always_comb begin
    spec1_nxt  = 1'b1;
    specv1_nxt = '0;
    if (dbl_is_nan(in_a)) begin
      specv1_nxt = in_a | DBL_QUIET_BIT;
    end else if (dbl_is_nan(in_b)) begin
      specv1_nxt = in_b | DBL_QUIET_BIT;
    end else if ((dbl_is_inf(in_a) && dbl_is_zero(in_b)) ||
                 (dbl_is_zero(in_a) && dbl_is_inf(in_b))) begin
      specv1_nxt = DBL_DEFAULT_NAN;
    end else if (dbl_is_inf(in_a) || dbl_is_inf(in_b)) begin
      specv1_nxt = {in_a[63] ^ in_b[63], DBL_EXP_MAX, 52'b0};
    end else if (dbl_is_zero(in_a) || dbl_is_zero(in_b)) begin
      specv1_nxt = {in_a[63] ^ in_b[63], 63'b0};
    end else begin
      spec1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r   <= in_tag;
      spec1_r  <= spec1_nxt;
      specv1_r <= specv1_nxt;
      sign1_r  <= in_a[63] ^ in_b[63];
      exp1_r   <= {2'b0, in_a[62:52]} + {2'b0, in_b[62:52]} - {2'b0, DBL_BIAS};
      hh1_r    <= ma[52:26] * mb[52:26];
      hl1_r    <= ma[52:26] * mb[25:0];
      lh1_r    <= ma[25:0] * mb[52:26];
      ll1_r    <= ma[25:0] * mb[25:0];
    end
  end

  // stage 2
  logic         vld2_r;
  tag_t         tag2_r;
  logic         spec2_r;
  logic [63:0]  specv2_r;
  logic         sign2_r;
  logic [12:0]  exp2_r;
  logic [105:0] prod2_r, prod2_nxt;
  logic [53:0]  mid;

  assign mid = {1'b0, hl1_r} + {1'b0, lh1_r};
  assign prod2_nxt = ({hh1_r, 52'b0}) + ({26'b0, mid, 26'b0}) + ({54'b0, ll1_r});

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r   <= tag1_r;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
      sign2_r  <= sign1_r;
      exp2_r   <= exp1_r;
      prod2_r  <= prod2_nxt;
    end
  end

  // stage 3: normalize by one and round
  logic        vld3_r;
  tag_t        tag3_r;
  logic [63:0] res3_r, res3_nxt;
  logic [51:0] m;
  logic [12:0] e;
  logic        g, st, rnd;

  always_comb begin
    if (prod2_r[105]) begin
      m  = prod2_r[104:53];
      g  = prod2_r[52];
      st = |prod2_r[51:0];
      e  = exp2_r + 13'd1;
    end else begin
      m  = prod2_r[103:52];
      g  = prod2_r[51];
      st = |prod2_r[50:0];
      e  = exp2_r;
    end
    rnd = g & (st | m[0]);
    res3_nxt = spec2_r ? specv2_r : {sign2_r, {e[10:0], m} + {62'b0, rnd}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r <= tag2_r;
      res3_r <= res3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  assign out_vld = vld3_r;
  assign out_res = res3_r;
  assign out_tag = tag3_r;

endmodule

// File: hw/rtl/tsis_dsub.sv
// ----------------------------------------------------------------------------
// tsis_dsub: six-stage double-precision 1.5 - p
// Order/swap, align with sticky, add, leading-zero count, normalize, round.
// ----------------------------------------------------------------------------
module tsis_dsub (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [63:0]    in_p,
  input  tsis_pkg::tag_t in_tag,
  output logic           out_vld,
  output logic [63:0]    out_res,
  output tsis_pkg::tag_t out_tag
);
  import tsis_pkg::*;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [5:0] vld_r;

  // stage 1: special values, order operands by magnitude
  tag_t        tag1_r;
  logic        spec1_r, spec1_nxt;
  logic [63:0] specv1_r, specv1_nxt;
  logic        sign1_r, sub1_r;
  logic [10:0] eb1_r, d1_r;
  logic [52:0] mbig1_r, msml1_r;
  logic [52:0] mp;
  logic        b_big;

  assign mp    = {1'b1, in_p[51:0]};
  assign b_big = (in_p[62:52] > DBL_BIAS) ||
                 ((in_p[62:52] == DBL_BIAS) && (mp > ONE_AND_HALF_MANT));

  always_comb begin
    spec1_nxt  = 1'b1;
    specv1_nxt = '0;
    if (dbl_is_nan(in_p)) begin
      specv1_nxt = in_p | DBL_QUIET_BIT;
    end else if (dbl_is_inf(in_p)) begin
      specv1_nxt = {~in_p[63], DBL_EXP_MAX, 52'b0};
    end else if (dbl_is_zero(in_p)) begin
      specv1_nxt = DBL_ONE_AND_HALF;
    end else begin
      spec1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r   <= in_tag;
      spec1_r  <= spec1_nxt;
      specv1_r <= specv1_nxt;
      sub1_r   <= ~in_p[63];
      if (b_big) begin
        sign1_r <= ~in_p[63];
        eb1_r   <= in_p[62:52];
        d1_r    <= in_p[62:52] - DBL_BIAS;
        mbig1_r <= mp;
        msml1_r <= ONE_AND_HALF_MANT;
      end else begin
        sign1_r <= 1'b0;
        eb1_r   <= DBL_BIAS;
        d1_r    <= DBL_BIAS - in_p[62:52];
        mbig1_r <= ONE_AND_HALF_MANT;
        msml1_r <= mp;
      end
    end
  end

  // stage 2: align the smaller operand, sticky into bit 0
  tag_t         tag2_r;
  logic         spec2_r, sign2_r, sub2_r;
  logic [63:0]  specv2_r;
  logic [10:0]  eb2_r;
  logic [55:0]  big2_r, sml2_r;
  logic [5:0]   dcl;
  logic [111:0] wide;

  assign dcl  = (d1_r > 11'd56) ? 6'd56 : d1_r[5:0];
  assign wide = {msml1_r, 3'b0, 56'b0} >> dcl;

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r   <= tag1_r;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
      sign2_r  <= sign1_r;
      sub2_r   <= sub1_r;
      eb2_r    <= eb1_r;
      big2_r   <= {mbig1_r, 3'b0};
      sml2_r   <= wide[111:56] | {55'b0, |wide[55:0]};
    end
  end

  // stage 3: add or subtract magnitudes
  tag_t        tag3_r;
  logic        spec3_r, sign3_r;
  logic [63:0] specv3_r;
  logic [10:0] eb3_r;
  logic [56:0] sum3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r   <= tag2_r;
      spec3_r  <= spec2_r;
      specv3_r <= specv2_r;
      sign3_r  <= sign2_r;
      eb3_r    <= eb2_r;
      sum3_r   <= sub2_r ? ({1'b0, big2_r} - {1'b0, sml2_r})
                         : ({1'b0, big2_r} + {1'b0, sml2_r});
    end
  end

  // stage 4: leading zeros
  tag_t        tag4_r;
  logic        spec4_r, sign4_r;
  logic [63:0] specv4_r;
  logic [10:0] eb4_r;
  logic [56:0] sum4_r;
  logic [5:0]  lz4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r   <= tag3_r;
      spec4_r  <= spec3_r;
      specv4_r <= specv3_r;
      sign4_r  <= sign3_r;
      eb4_r    <= eb3_r;
      sum4_r   <= sum3_r;
      lz4_r    <= lzc56(sum3_r[55:0]);
    end
  end

  // stage 5: normalize
  tag_t        tag5_r;
  logic        spec5_r, sign5_r, zero5_r;
  logic [63:0] specv5_r;
  logic [11:0] e5_r, e5_nxt;
  logic [55:0] n5_r, n5_nxt;

  always_comb begin
    if (sum4_r[56]) begin
      n5_nxt = {sum4_r[56:2], sum4_r[1] | sum4_r[0]};
      e5_nxt = {1'b0, eb4_r} + 12'd1;
    end else begin
      n5_nxt = sum4_r[55:0] << lz4_r;
      e5_nxt = {1'b0, eb4_r} - {6'b0, lz4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag5_r   <= tag4_r;
      spec5_r  <= spec4_r;
      specv5_r <= specv4_r;
      sign5_r  <= sign4_r;
      zero5_r  <= (sum4_r == '0);
      n5_r     <= n5_nxt;
      e5_r     <= e5_nxt;
    end
  end

  // stage 6: round to nearest-even
  tag_t        tag6_r;
  logic [63:0] res6_r, res6_nxt;
  logic        rnd;

  always_comb begin
    rnd = n5_r[2] & (n5_r[1] | n5_r[0] | n5_r[3]);
    if (spec5_r) begin
      res6_nxt = specv5_r;
    end else if (zero5_r) begin
      res6_nxt = '0;
    end else begin
      res6_nxt = {sign5_r, {e5_r[10:0], n5_r[54:3]} + {62'b0, rnd}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag6_r <= tag5_r;
      res6_r <= res6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  assign out_vld = vld_r[5];
  assign out_res = res6_r;
  assign out_tag = tag6_r;

endmodule

// File: hw/rtl/table_seeded_inverse_sqrt.sv
// ----------------------------------------------------------------------------
// table_seeded_inverse_sqrt: pipelined float32 reciprocal square root
// Table seed followed by up to three Newton steps in double precision.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the output is not stalled, and the
// throughput is one word per clock under that condition. The pipeline holds
// an input register, the registered seed-table read, three refinement stages
// (each two multipliers, a subtract and a multiplier) and the output
// register. All three refinement stages are always traversed; newton_steps
// picks how many of them update the estimate. A stall on the output freezes
// the whole pipeline.
// newton_steps sits at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module table_seeded_inverse_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tsis_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_value_bits,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_result_bits
);
  import tsis_pkg::*;

  localparam seed_rom_t SEED_ROM = seed_rom_build();

  // x * 0.5 in single, widened to double
  function automatic logic [63:0] half_to_dbl(input logic [31:0] x);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] v;
    logic [23:0] f;
    logic [4:0]  p;
    logic [52:0] sh;
    ex = x[30:23];
    fr = x[22:0];
    p  = '0;
    if (ex == 8'hFF) begin
      return {x[31], DBL_EXP_MAX, fr | ((fr != '0) ? 23'h40_0000 : 23'h0), 29'b0};
    end else if (ex >= 8'd2) begin
      return {x[31], 11'({3'b0, ex} + 11'd895), fr, 29'b0};
    end else begin
      v = {(ex == 8'd1), fr};
      f = (v >> 1) + {23'b0, v[0] & v[1]};
      if (f == '0) return {x[31], 63'b0};
      for (int i = 0; i < 24; i++) begin
        if (f[i]) p = 5'(i);
      end
      sh = {29'b0, f} << (6'd52 - {1'b0, p});
      return {x[31], 11'({6'b0, p} + 11'd874), sh[51:0]};
    end
  endfunction

  // double to single, nearest-even; result range stays within normal singles
  function automatic logic [31:0] dbl_to_sgl(input logic [63:0] d);
    logic [7:0] fe;
    logic       rnd;
    fe  = 8'(d[62:52] - 11'd896);
    rnd = d[28] & ((|d[27:0]) | d[29]);
    if (d[62:52] == DBL_EXP_MAX) begin
      return {d[63], 8'hFF, d[51:29] | ((d[51:0] != '0) ? 23'h40_0000 : 23'h0)};
    end else if (d[62:52] == '0) begin
      return {d[63], 31'b0};
    end else begin
      return {d[63], {fe, d[51:29]} + {30'b0, rnd}};
    end
  endfunction

  // register port
  logic [1:0] newton_steps_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_NEWTON_STEPS) ? {30'b0, newton_steps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newton_steps_r <= NEWTON_STEPS_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_NEWTON_STEPS)) begin
      newton_steps_r <= cfg_pwdata[1:0];
    end
  end

  // pipeline advance: everything moves unless the output word is held
  logic adv;
  logic out_valid_r;
  logic [31:0] out_bits_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // input register
  logic        vld0_r;
  logic [31:0] x0_r;

  // seed read and half operand
  logic        vld1_r;
  logic [7:0]  seed1_r;
  logic [7:0]  se1_r;
  logic [63:0] y1_r;
  logic [8:0]  se_diff;

  assign se_diff = 9'd380 - {1'b0, x0_r[30:23]};

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r    <= in_value_bits;
      seed1_r <= SEED_ROM[x0_r[23:15]];
      se1_r   <= se_diff[8:1];
      y1_r    <= half_to_dbl(x0_r);
    end
  end

  // refinement stages
  logic [NEWTON_MAX:0] it_vld;
  logic [63:0]         it_r [NEWTON_MAX+1];
  logic [63:0]         it_y [NEWTON_MAX+1];

  assign it_vld[0] = vld1_r;
  assign it_r[0]   = {1'b0, 11'({3'b0, se1_r} + 11'd896), seed1_r, 44'b0};
  assign it_y[0]   = y1_r;

  for (genvar k = 0; k < NEWTON_MAX; k++) begin : g_iter
    tag_t        tg0, tg1, tg2, tg3, tg4;
    logic        v1, v2, v3, v4;
    logic [63:0] sq, py, t, rn;

    assign tg0 = '{r: it_r[k], y: it_y[k]};

    tsis_dmul u_mul_sq (
      .clk, .rst_n, .en(adv), .in_vld(it_vld[k]),
      .in_a(it_r[k]), .in_b(it_r[k]), .in_tag(tg0),
      .out_vld(v1), .out_res(sq), .out_tag(tg1)
    );

    tsis_dmul u_mul_y (
      .clk, .rst_n, .en(adv), .in_vld(v1),
      .in_a(sq), .in_b(tg1.y), .in_tag(tg1),
      .out_vld(v2), .out_res(py), .out_tag(tg2)
    );

    tsis_dsub u_sub (
      .clk, .rst_n, .en(adv), .in_vld(v2),
      .in_p(py), .in_tag(tg2),
      .out_vld(v3), .out_res(t), .out_tag(tg3)
    );

    tsis_dmul u_mul_r (
      .clk, .rst_n, .en(adv), .in_vld(v3),
      .in_a(tg3.r), .in_b(t), .in_tag(tg3),
      .out_vld(v4), .out_res(rn), .out_tag(tg4)
    );

    // stages beyond newton_steps pass the estimate through untouched
    assign it_vld[k+1] = v4;
    assign it_r[k+1]   = (newton_steps_r > 2'(k)) ? rn : tg4.r;
    assign it_y[k+1]   = tg4.y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bits_r <= dbl_to_sgl(it_r[NEWTON_MAX]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r      <= 1'b0;
      vld1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld0_r      <= in_valid;
      vld1_r      <= vld0_r;
      out_valid_r <= it_vld[NEWTON_MAX];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

endmodule
